// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ----- hdl/ibm_pkg.sv -----
// ----------------------------------------------------------------------------
// Inode bitmap allocator package
// Operation and error codes, sequencer states and the byte unit result type.
// ----------------------------------------------------------------------------
package ibm_pkg;

  localparam int KIND_W  = 2;
  localparam int INODE_W = 17;
  localparam int ERR_W   = 2;
  localparam int CFG_W   = 4;

  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  localparam logic [CFG_W-1:0] BLOCKS_RESET = 4'd8;

  localparam logic [7:0] FULL_BYTE = 8'hff;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RMW   = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic       bit_value;
    logic [7:0] new_byte;
    logic [2:0] first_zero;
    logic       full;
  } byte_info_t;

endpackage

// ----- hdl/inode_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// Inode bitmap allocator
// Allocation bitmap with bit read, bit write and find-first-free commands.
// ----------------------------------------------------------------------------
// A command word is taken on a rising edge with start high and busy low:
// kind selects read bit, write bit or find first free inode. Each command
// gives one result word on bit_status, found_inode and error_code, shown for
// exactly one cycle while done is high; the receiver cannot stall it.
// Read and write read the byte from the bitmap RAM and then test it or write
// it back, with done in the cycle after that. Out-of-range inodes, unused kinds
// and an empty map give done in the cycle after accept. Find scans one byte
// per cycle through the RAM read port and stops at the first non-full byte or
// at the last byte of the blocks in use. After reset the block clears all
// MAP_BLOCKS*BITS_PER_BLOCK/8 bytes of the bitmap RAM (8192 by default) one
// byte a cycle; busy is high then. The blocks_in_use register is written
// through cfg_valid/cfg_ready; the user must write it only while no command
// is in flight, which the block itself does not enforce. It resets to 8.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module inode_bitmap_allocator #(
  parameter int MAP_BLOCKS     = 8,
  parameter int BITS_PER_BLOCK = 8192
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ibm_pkg::KIND_W-1:0]   kind,
  input  logic [ibm_pkg::INODE_W-1:0]  inode_number,
  input  logic                         set_value,
  output logic                         done,
  output logic                         bit_status,
  output logic [ibm_pkg::INODE_W-1:0]  found_inode,
  output logic [ibm_pkg::ERR_W-1:0]    error_code,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ibm_pkg::CFG_W-1:0]    cfg_data
);

  localparam int BYTES_PER_BLOCK = BITS_PER_BLOCK / 8;
  localparam int TOTAL_BYTES     = MAP_BLOCKS * BYTES_PER_BLOCK;
  localparam int ADRW            = (TOTAL_BYTES > 1) ? $clog2(TOTAL_BYTES) : 1;
  localparam int CNTW            = $clog2(TOTAL_BYTES + 1);
  localparam int LIMW            = $clog2(MAP_BLOCKS * BITS_PER_BLOCK + 1);
  localparam int CMPW            = (LIMW > ibm_pkg::INODE_W) ? LIMW : ibm_pkg::INODE_W;
  localparam int IDXW            = (ADRW + 3 > ibm_pkg::INODE_W) ? ADRW + 3
                                                                 : ibm_pkg::INODE_W;
  localparam int FW              = (ADRW + 4 > ibm_pkg::INODE_W) ? ADRW + 4
                                                                 : ibm_pkg::INODE_W;
  localparam int ACTW            = ($clog2(MAP_BLOCKS + 1) > ibm_pkg::CFG_W)
                                   ? $clog2(MAP_BLOCKS + 1) : ibm_pkg::CFG_W;

  ibm_pkg::state_t state, state_next;

  logic [ibm_pkg::CFG_W-1:0]   blocks_in_use;
  logic [ADRW-1:0]             clr_addr;
  logic [ADRW-1:0]             chk_addr, chk_addr_next;
  logic [ibm_pkg::KIND_W-1:0]  op_kind, op_kind_next;
  logic [ADRW-1:0]             op_addr, op_addr_next;
  logic [2:0]                  op_shift, op_shift_next;
  logic                        op_setv, op_setv_next;

  logic                        resp_valid;
  logic                        resp_bit;
  logic [ibm_pkg::INODE_W-1:0] resp_found;
  logic [ibm_pkg::ERR_W-1:0]   resp_err;

  logic [ACTW-1:0]             active;
  logic [CMPW-1:0]             limit;
  logic [CNTW-1:0]             nbytes;
  logic [CMPW-1:0]             inode_ext;
  logic [IDXW-1:0]             idx;
  logic                        inode_ok;
  logic                        scan_last;
  logic [FW-1:0]               found_sum;

  logic                        ram_we;
  logic [ADRW-1:0]             ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [ADRW-1:0]             ram_raddr;
  logic [7:0]                  ram_rdata;

  ibm_pkg::byte_info_t         info;

  assign busy      = (state != ibm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Blocks beyond the built map saturate to the map size.
  assign active = (ACTW'(blocks_in_use) > ACTW'(MAP_BLOCKS))
                  ? ACTW'(MAP_BLOCKS)
                  : ACTW'(blocks_in_use);
  assign limit     = CMPW'(active) * CMPW'(BITS_PER_BLOCK);
  assign nbytes    = CNTW'(active) * CNTW'(BYTES_PER_BLOCK);
  assign inode_ext = CMPW'(inode_number);
  assign inode_ok  = (inode_ext != '0) && (inode_ext <= limit);
  assign idx       = IDXW'(inode_number) - IDXW'(1);
  assign scan_last = ((CNTW'(chk_addr) + CNTW'(1)) == nbytes);
  assign found_sum = FW'({chk_addr, info.first_zero}) + FW'(1);

  ibm_byte_unit u_byte_unit (
    .data_byte (ram_rdata),
    .bit_sel   (op_shift),
    .set_value (op_setv),
    .info      (info)
  );

  ibm_bitmap_ram #(
    .DEPTH (TOTAL_BYTES),
    .AW    (ADRW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next    = state;
    chk_addr_next = chk_addr;
    op_kind_next  = op_kind;
    op_addr_next  = op_addr;
    op_shift_next = op_shift;
    op_setv_next  = op_setv;
    resp_valid    = 1'b0;
    resp_bit      = 1'b0;
    resp_found    = '0;
    resp_err      = ibm_pkg::ERR_OK;
    ram_we        = 1'b0;
    ram_waddr     = clr_addr;
    ram_wdata     = 8'h00;
    ram_raddr     = idx[ADRW+2:3];

    unique case (state)
      ibm_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == ADRW'(TOTAL_BYTES - 1)) begin
          state_next = ibm_pkg::ST_IDLE;
        end
      end
      ibm_pkg::ST_IDLE: begin
        if (start) begin
          op_kind_next  = kind;
          op_addr_next  = idx[ADRW+2:3];
          op_shift_next = idx[2:0];
          op_setv_next  = set_value;
          unique case (kind) inside
            ibm_pkg::KIND_READ, ibm_pkg::KIND_WRITE: begin
              if (inode_ok) begin
                state_next = ibm_pkg::ST_RMW;
              end else begin
                resp_valid = 1'b1;
                resp_err   = ibm_pkg::ERR_RANGE;
              end
            end
            ibm_pkg::KIND_FIND: begin
              ram_raddr     = '0;
              chk_addr_next = '0;
              if (nbytes == '0) begin
                resp_valid = 1'b1;
                resp_err   = ibm_pkg::ERR_FULL;
              end else begin
                state_next = ibm_pkg::ST_SCAN;
              end
            end
            default: begin
              resp_valid = 1'b1;
            end
          endcase
        end
      end
      ibm_pkg::ST_RMW: begin
        resp_valid = 1'b1;
        state_next = ibm_pkg::ST_IDLE;
        if (op_kind == ibm_pkg::KIND_READ) begin
          resp_bit = info.bit_value;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = op_addr;
          ram_wdata = info.new_byte;
        end
      end
      ibm_pkg::ST_SCAN: begin
        // The next byte is requested while the current one is checked.
        ram_raddr = chk_addr + ADRW'(1);
        if (!info.full) begin
          resp_valid = 1'b1;
          resp_found = found_sum[ibm_pkg::INODE_W-1:0];
          state_next = ibm_pkg::ST_IDLE;
        end else if (scan_last) begin
          resp_valid = 1'b1;
          resp_err   = ibm_pkg::ERR_FULL;
          state_next = ibm_pkg::ST_IDLE;
        end else begin
          chk_addr_next = chk_addr + ADRW'(1);
        end
      end
      default: begin
        state_next = ibm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ibm_pkg::ST_CLEAR;
      clr_addr      <= '0;
      blocks_in_use <= ibm_pkg::BLOCKS_RESET;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= resp_valid;
      if (state == ibm_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + ADRW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        blocks_in_use <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr    <= chk_addr_next;
    op_kind     <= op_kind_next;
    op_addr     <= op_addr_next;
    op_shift    <= op_shift_next;
    op_setv     <= op_setv_next;
    bit_status  <= resp_bit;
    found_inode <= resp_found;
    error_code  <= resp_err;
  end

  `ASSERT_PROP(a_no_done_after_clear, clk, rst, done |-> ($past(state) != ibm_pkg::ST_CLEAR), "result word right after a clear cycle")
  `ASSERT_PROP(a_accept_progress, clk, rst, (start && !busy) |=> (busy || done), "accepted command neither in progress nor answered")
  `ASSERT_NEVER(a_error_fields_zero, clk, rst, done && (error_code != ibm_pkg::ERR_OK) && (bit_status || (found_inode != '0)), "error result with nonzero data fields")

endmodule

// ----- hdl/ibm_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// Bitmap RAM
// Byte-wide single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module ibm_bitmap_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ibm_byte_unit.sv -----
// ----------------------------------------------------------------------------
// Byte unit
// Bit test, bit update and first-zero search on one bitmap byte.
// ----------------------------------------------------------------------------
module ibm_byte_unit (
  input  logic               [7:0] data_byte,
  input  logic               [2:0] bit_sel,
  input  logic                     set_value,
  output ibm_pkg::byte_info_t      info
);

  logic [2:0] first_zero;

  // Bits 0 to 6 are searched; a non-full byte with those all set has bit 7 clear.
  always_comb begin
    first_zero = 3'd7;
    for (int k = 6; k >= 0; k--) begin
      if (!data_byte[k]) begin
        first_zero = 3'(k);
      end
    end
  end

  always_comb begin
    info.bit_value  = data_byte[bit_sel];
    info.new_byte   = data_byte;
    info.new_byte[bit_sel] = set_value;
    info.first_zero = first_zero;
    info.full       = (data_byte == ibm_pkg::FULL_BYTE);
  end

endmodule
